FILE: sv/deq_pkg.sv
package deq_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 64;
    localparam int STAT_W = 2;
    localparam int FILL_W = 7;

    localparam logic [OP_W-1:0] OP_ADD_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_TAIL = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_deq_state;

    // Per-beat control handed from the index logic to the response stage.
    typedef struct packed {
        logic              busy;       // a memory read is in flight
        logic              defer;      // accepted beat waits for read data
        logic              rd_done;    // read data is valid this cycle
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill_count;
    } t_deq_ack;

endpackage

FILE: sv/deq_if.sv
interface deq_in_if;
    import deq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] entry_in;
    logic              remove_flag;

    modport source (output valid, output opcode, output entry_in, output remove_flag,
                    input ready);
    modport sink   (input valid, input opcode, input entry_in, input remove_flag,
                    output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] entry_out;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, output status, output entry_out, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input entry_out, input fill_count,
                    output ready);
endinterface

FILE: sv/deq_ram.sv
module deq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/deq_ctrl.sv
module deq_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [deq_pkg::OP_W-1:0]       i_opcode,
    input  logic [deq_pkg::DATA_W-1:0]     i_entry_in,
    input  logic                           i_remove_flag,
    output logic                           o_mem_we,
    output logic                           o_mem_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_mem_addr,
    output logic [8*ENTRY_BYTES-1:0]       o_mem_wdata,
    output deq_pkg::t_deq_ack              o_ack
);
    import deq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 8 * ENTRY_BYTES;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    t_deq_state r_state, n_state;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_init, n_init;

    logic              live;
    logic              rd_live;
    logic [IW-1:0]     head_next, head_prev, tail_next, tail_prev;
    logic [STAT_W-1:0] status;
    logic [CW+FILL_W-1:0] fill_ext;

    assign live      = r_init && (r_count != '0);
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign rd_live   = live && (i_opcode == OP_READ_HEAD || i_opcode == OP_READ_TAIL);

    // Index, count and memory access for the operation on the input bus.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_init      = r_init;
        status      = STAT_OK;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_addr  = '0;
        o_mem_wdata = i_entry_in[EW-1:0];
        case (i_opcode)
            OP_ADD_FIRST: begin
                n_head   = '0;
                n_tail   = '0;
                n_count  = ONE_CNT;
                n_init   = 1'b1;
                o_mem_we = i_accept;
            end
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                if (!live) begin
                    status = STAT_EMPTY;
                end else if (r_count == FULL_CNT) begin
                    status = STAT_FULL;
                end else begin
                    o_mem_we = i_accept;
                    n_count  = r_count + 1'b1;
                    if (i_opcode == OP_PUSH_HEAD) begin
                        n_head     = head_next;
                        o_mem_addr = head_next;
                    end else begin
                        n_tail     = tail_prev;
                        o_mem_addr = tail_prev;
                    end
                end
            end
            OP_READ_HEAD, OP_READ_TAIL: begin
                if (!live) begin
                    status = STAT_EMPTY;
                end else begin
                    o_mem_re   = i_accept;
                    o_mem_addr = (i_opcode == OP_READ_HEAD) ? r_head : r_tail;
                    if (i_remove_flag) begin
                        if (r_count <= ONE_CNT) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_init  = 1'b0;
                        end else begin
                            n_count = r_count - 1'b1;
                            if (i_opcode == OP_READ_HEAD) begin
                                n_head = head_prev;
                            end else begin
                                n_tail = tail_next;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = (i_accept && rd_live) ? S_READ : S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The fill count port keeps only the low bits of the count.
    assign fill_ext = {{FILL_W{1'b0}}, n_count};

    always_comb begin
        o_ack.busy       = 1'b0;
        o_ack.rd_done    = 1'b0;
        o_ack.defer      = rd_live;
        o_ack.status     = status;
        o_ack.fill_count = fill_ext[FILL_W-1:0];
        unique case (r_state)
            S_IDLE: begin
            end
            S_READ: begin
                o_ack.busy    = 1'b1;
                o_ack.rd_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_init  <= n_init;
            end
        end
    end

endmodule

FILE: sv/double_ended_queue.sv
// A push, add_first, rejected or unused operation has its result registered at the accepting edge;
// a read of a live queue first enters the read state, and its result is registered from the memory after that.
// One operation per cycle while the output slot is free, except that a read of a live queue holds off the next
// beat during its read state, set by the registered read port of the single-port entry memory.
// Reset clears the indices, count and initialized flag; the entry memory is not cleared.
module double_ended_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_in_if.sink     i_cmd,
    deq_out_if.source  o_rsp
);
    import deq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int EW = 8 * ENTRY_BYTES;

    t_deq_ack ack;
    logic          accept;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_entry;
    logic [FILL_W-1:0] r_fill;

    // A new beat is taken once no read is in flight and the output slot frees up.
    assign i_cmd.ready = !ack.busy && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    deq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_cmd.opcode),
        .i_entry_in    (i_cmd.entry_in),
        .i_remove_flag (i_cmd.remove_flag),
        .o_mem_we      (mem_we),
        .o_mem_re      (mem_re),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .o_ack         (ack)
    );

    deq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ack.rd_done || (accept && !ack.defer)) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= ack.status;
            r_fill   <= ack.fill_count;
            r_entry  <= '0;
        end else if (ack.rd_done) begin
            r_entry <= DATA_W'(mem_rdata);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.entry_out  = r_entry;
    assign o_rsp.fill_count = r_fill;

    a_read_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ack.defer |=> ack.rd_done && !i_cmd.ready)
        else $error("live read did not enter the read cycle");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ack.rd_done |=> r_out_valid && r_status == STAT_OK)
        else $error("read data did not reach the output register");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != STAT_OK |-> r_entry == '0)
        else $error("rejected operation carries entry data");

endmodule

FILE: bench/deq_checker.sv
module deq_checker
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    deq_in_if    i_cmd,
    deq_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - 8 * ENTRY_BYTES);
    localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] entry_out;
        logic [FILL_W-1:0] fill_count;
    } t_deq_result;

    // Shadow copy of the ring: head and tail name the slots of the end entries.
    logic [DATA_W-1:0] slot_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]  head_slot;
    logic [IDX_W-1:0]  tail_slot;
    logic [FILL_W-1:0] held;
    logic              started;

    t_deq_result results_due [$];
    t_deq_result got;
    t_deq_result want;

    function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    function automatic t_deq_result apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic drop);
        t_deq_result res;
        logic        live;
        res.status    = STAT_OK;
        res.entry_out = '0;
        live          = started && (held != 0);
        case (op)
            OP_ADD_FIRST: begin
                head_slot   = '0;
                tail_slot   = '0;
                slot_mem[0] = data & ENTRY_MASK;
                held        = FILL_W'(1);
                started     = 1'b1;
            end
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                if (!live) begin
                    res.status = STAT_EMPTY;
                end else if (held >= QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                end else if (op == OP_PUSH_HEAD) begin
                    head_slot           = slot_next(head_slot);
                    slot_mem[head_slot] = data & ENTRY_MASK;
                    held                = held + 1'b1;
                end else begin
                    tail_slot           = slot_prev(tail_slot);
                    slot_mem[tail_slot] = data & ENTRY_MASK;
                    held                = held + 1'b1;
                end
            end
            OP_READ_HEAD, OP_READ_TAIL: begin
                if (!live) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.entry_out = (op == OP_READ_HEAD) ? slot_mem[head_slot]
                                                         : slot_mem[tail_slot];
                    if (drop) begin
                        // Taking the last entry leaves the queue unstarted again.
                        if (held <= 1) begin
                            head_slot = '0;
                            tail_slot = '0;
                            held      = '0;
                            started   = 1'b0;
                        end else begin
                            if (op == OP_READ_HEAD) begin
                                head_slot = slot_prev(head_slot);
                            end else begin
                                tail_slot = slot_next(tail_slot);
                            end
                            held = held - 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.fill_count = held;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot = '0;
            tail_slot = '0;
            held      = '0;
            started   = 1'b0;
            results_due.delete();
        end else begin
            // Results always trail their command, so retire before queuing the new one.
            if (i_rsp.valid && i_rsp.ready) begin
                got.status     = i_rsp.status;
                got.entry_out  = i_rsp.entry_out;
                got.fill_count = i_rsp.fill_count;
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: status %0d entry_out %h fill_count %0d",
                           got.status, got.entry_out, got.fill_count);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.entry_out !== want.entry_out) begin
                        $error("entry_out: expected %h, got %h", want.entry_out, got.entry_out);
                        o_fail_count++;
                    end
                    if (got.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, got.fill_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                results_due.push_back(apply_deque_op(i_cmd.opcode, i_cmd.entry_in,
                                                     i_cmd.remove_flag));
            end
        end
        o_pending = results_due.size();
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import deq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 64;
    localparam int ENTRY_BYTES  = 8;
    localparam int RANDOM_BEATS = 650;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_READ_TAIL + 1'b1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    logic i_clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   beats_sent;
    int   idle_cycles;

    deq_in_if  cmd_if ();
    deq_out_if rsp_if ();

    double_ended_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ENTRY_BYTES(ENTRY_BYTES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    deq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ENTRY_BYTES(ENTRY_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_if),
        .i_rsp       (rsp_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DATA_W-1:0] pick_entry();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            return OP_ADD_FIRST;
        end else if (roll < 45) begin
            return $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        end else if (roll < 95) begin
            return $urandom_range(0, 1) ? OP_READ_HEAD : OP_READ_TAIL;
        end
        return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    // Called right after a rising edge; returns right after the edge that took the beat.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                             input logic drop);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.opcode      <= op;
        cmd_if.entry_in    <= data;
        cmd_if.remove_flag <= drop;
        @(negedge i_clk);
        while (!cmd_if.ready) @(negedge i_clk);
        @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Result side: ready windows of random length broken by gaps.
    initial begin
        int hold;
        int gap;
        rsp_if.ready = 1'b0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            hold = calm ? 1 : $urandom_range(1, 8);
            rsp_if.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int first_random;
        int seg_len;
        logic [OP_W-1:0] op;
        cmd_if.valid       = 1'b0;
        cmd_if.opcode      = OP_ADD_FIRST;
        cmd_if.entry_in    = '0;
        cmd_if.remove_flag = 1'b0;
        rst_n              = 1'b0;
        calm               = 1'b0;
        beats_sent         = 0;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Every read and push on a queue that was never started is turned away; an unused opcode does nothing.
        send_beat(OP_READ_HEAD, '1, 1'b1);
        send_beat(OP_READ_TAIL, '0, 1'b0);
        send_beat(OP_PUSH_HEAD, '1, 1'b0);
        send_beat(OP_PUSH_TAIL, 64'h0123_4567_89ab_cdef, 1'b1);
        send_beat(OP_SPARE_LO, '1, 1'b1);
        // One entry, then removing it stops the queue again.
        send_beat(OP_ADD_FIRST, '1, 1'b1);
        send_beat(OP_READ_HEAD, '0, 1'b0);
        send_beat(OP_READ_TAIL, '0, 1'b1);
        send_beat(OP_PUSH_HEAD, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0);
        send_beat(OP_READ_HEAD, '0, 1'b1);
        // Both ends, peeks and removals.
        send_beat(OP_ADD_FIRST, '0, 1'b0);
        send_beat(OP_PUSH_HEAD, '1, 1'b1);
        send_beat(OP_PUSH_TAIL, 64'h5555_5555_5555_5555, 1'b0);
        send_beat(OP_PUSH_HEAD, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        send_beat(OP_READ_HEAD, '0, 1'b0);
        send_beat(OP_READ_TAIL, '0, 1'b0);
        send_beat(OP_READ_HEAD, '0, 1'b1);
        send_beat(OP_READ_TAIL, '1, 1'b1);
        // A restart over live entries drops them.
        send_beat(OP_ADD_FIRST, 64'h8000_0000_0000_0001, 1'b1);
        send_beat(OP_READ_TAIL, '0, 1'b0);
        send_beat(OP_SPARE_HI, 64'hffff_0000_ffff_0000, 1'b0);
        send_beat(OP_READ_TAIL, '0, 1'b1);
        send_beat(OP_READ_HEAD, '0, 1'b1);
        wait_for_results();

        first_random = beats_sent;
        while (beats_sent - first_random < RANDOM_BEATS) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: begin
                    // Fill run: long enough to reach the full store now and then.
                    send_beat(OP_ADD_FIRST, pick_entry(), 1'($urandom_range(0, 1)));
                    seg_len = $urandom_range(20, 70);
                    repeat (seg_len) begin
                        op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
                        send_beat(op, pick_entry(), 1'($urandom_range(0, 1)));
                    end
                end
                1: begin
                    // Drain run: mostly removals, running past empty at times.
                    seg_len = $urandom_range(10, 70);
                    repeat (seg_len) begin
                        op = $urandom_range(0, 1) ? OP_READ_HEAD : OP_READ_TAIL;
                        send_beat(op, pick_entry(), $urandom_range(0, 9) != 0);
                    end
                end
                default: begin
                    if ($urandom_range(0, 1)) begin
                        send_beat(OP_ADD_FIRST, pick_entry(), 1'($urandom_range(0, 1)));
                    end
                    seg_len = $urandom_range(10, 40);
                    repeat (seg_len) send_beat(pick_op(), pick_entry(),
                                               1'($urandom_range(0, 1)));
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                wait_for_results();
            end
        end

        calm = 1'b0;
        wait_for_results();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/double_ended_queue.sv
bench/deq_checker.sv
bench/tb_top.sv
